// File: src/rpo_pkg.sv
package rpo_pkg;

    // fixed field widths
    localparam int FREQ_BITS   = 23;
    localparam int RAMP_FRAC   = 16;
    localparam int HZ_BITS     = 28;
    localparam int SAMPLE_BITS = 16;
    localparam int SINE_BITS   = 15;

    // parameter defaults
    localparam int SEG_LEN_BITS_DEF   = 16;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int AMP_BITS_DEF       = 16;

    localparam logic [HZ_BITS-1:0] HZ_RESET = 28'd22906493;

    // register index of hz_to_phase_step, byte address 4*index
    localparam int REG_HZ_IDX = 0;

    // odd-power sine polynomial, Q30
    localparam logic signed [31:0] COEF_C1 = 32'sd1686629713;
    localparam logic signed [31:0] COEF_C3 = -32'sd693598668;
    localparam logic signed [31:0] COEF_C5 = 32'sd85569306;
    localparam logic signed [31:0] COEF_C7 = -32'sd5026995;
    localparam logic signed [31:0] COEF_C9 = 32'sd172272;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_TICK = 2'd0;
    localparam opcode_t OP_LOAD = 2'd1;
    localparam opcode_t OP_NEW  = 2'd2;

    // multiplier operand selection
    typedef logic [2:0] mul_sel_t;
    localparam mul_sel_t MUL_NONE = 3'd0;
    localparam mul_sel_t MUL_TT   = 3'd1;
    localparam mul_sel_t MUL_PT2  = 3'd2;
    localparam mul_sel_t MUL_PT   = 3'd3;
    localparam mul_sel_t MUL_AMP  = 3'd4;
    localparam mul_sel_t MUL_FRQ  = 3'd5;

    // what to do with the registered product
    typedef logic [3:0] post_sel_t;
    localparam post_sel_t POST_NONE = 4'd0;
    localparam post_sel_t POST_T2   = 4'd1;
    localparam post_sel_t POST_P7   = 4'd2;
    localparam post_sel_t POST_P5   = 4'd3;
    localparam post_sel_t POST_P3   = 4'd4;
    localparam post_sel_t POST_P1   = 4'd5;
    localparam post_sel_t POST_Y    = 4'd6;
    localparam post_sel_t POST_S    = 4'd7;
    localparam post_sel_t POST_SMP  = 4'd8;
    localparam post_sel_t POST_UPD  = 4'd9;

    typedef struct packed {
        mul_sel_t  mul_sel;
        post_sel_t post_sel;
    } uop_t;

    typedef struct packed {
        logic      phase_clr;
        logic      seg_load;
        logic      div_step;
        logic      div_amp_done;
        logic      div_freq_done;
        mul_sel_t  mul_sel;
        post_sel_t post_sel;
        logic      out_load;
        logic      out_idle;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic samples_zero;
    } stat_t;

    localparam int TICK_STEPS  = 17;
    localparam int TICK_STEP_W = $clog2(TICK_STEPS);

    function automatic int div_width(input int amp_bits);
        return ((amp_bits > FREQ_BITS) ? amp_bits : FREQ_BITS) + RAMP_FRAC;
    endfunction

    // per-sample microsequence: each multiply step is followed by a post step on its product
    function automatic uop_t tick_uop(input logic [TICK_STEP_W-1:0] step);
        uop_t u;
        u.mul_sel  = MUL_NONE;
        u.post_sel = POST_NONE;
        case (step)
            5'd0:  u.mul_sel  = MUL_TT;
            5'd1:  u.post_sel = POST_T2;
            5'd2:  u.mul_sel  = MUL_PT2;
            5'd3:  u.post_sel = POST_P7;
            5'd4:  u.mul_sel  = MUL_PT2;
            5'd5:  u.post_sel = POST_P5;
            5'd6:  u.mul_sel  = MUL_PT2;
            5'd7:  u.post_sel = POST_P3;
            5'd8:  u.mul_sel  = MUL_PT2;
            5'd9:  u.post_sel = POST_P1;
            5'd10: u.mul_sel  = MUL_PT;
            5'd11: u.post_sel = POST_Y;
            5'd12: u.post_sel = POST_S;
            5'd13: u.mul_sel  = MUL_AMP;
            5'd14: u.post_sel = POST_SMP;
            5'd15: u.mul_sel  = MUL_FRQ;
            5'd16: u.post_sel = POST_UPD;
            default: u.mul_sel = MUL_NONE;
        endcase
        return u;
    endfunction

endpackage

// File: src/ramped_partial_oscillator_top.sv
// Sample path: a tick word runs 17 sequencer steps on one shared 32x32 multiplier, then
//   loads the output register; an idle tick goes straight to the output register.
// Flow: s_tready is high only while idle, so a word is taken only once the last one is done;
//   a segment load holds s_tready low through the bit-serial restoring divider.
// Reset: aresetn synchronous, active low; clears phase, ramps and sample count, rate
//   register back to the 48 kHz value, no word in flight.
module ramped_partial_oscillator_top #(
    parameter int SEG_LEN_BITS   = rpo_pkg::SEG_LEN_BITS_DEF,
    parameter int SINE_ADDR_BITS = rpo_pkg::SINE_ADDR_BITS_DEF,
    parameter int AMP_BITS       = rpo_pkg::AMP_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input word stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // start_amp, end_amp, start_freq, end_freq, seg_length
    input  logic [1:0]  s_tuser,   // opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample
    output logic        m_tlast,   // segment_last
    output logic [0:0]  m_tuser,   // idle
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // word 0 at byte 0: hz_to_phase_step
    localparam logic [0:0] REG_HZ = 1'(rpo_pkg::REG_HZ_IDX);

    logic [rpo_pkg::HZ_BITS-1:0] hz_reg, hz_next;
    rpo_pkg::cmd_t  cmd;
    rpo_pkg::stat_t stat;

    // tdata field unpacking (lowest first)
    logic [15:0] start_amp, end_amp, seg_length;
    logic [22:0] start_freq, end_freq;

    assign start_amp  = s_tdata[15:0];
    assign end_amp    = s_tdata[31:16];
    assign start_freq = s_tdata[54:32];
    assign end_freq   = s_tdata[77:55];
    assign seg_length = s_tdata[93:78];

    // APB: no wait states, write lands on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_HZ) ? 32'(hz_reg) : '0;

    always_comb begin
        hz_next = hz_reg;
        if (psel && penable && pwrite && pready && paddr[2:2] == REG_HZ) begin
            hz_next = pwdata[rpo_pkg::HZ_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hz_reg <= rpo_pkg::HZ_RESET;
        end else begin
            hz_reg <= hz_next;
        end
    end

    // sequencer: handshakes, divide count, per-sample microsequence
    rpo_ctrl #(
        .AMP_BITS (AMP_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: ramps, divider, sine polynomial, output register
    rpo_dp #(
        .SEG_LEN_BITS   (SEG_LEN_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .AMP_BITS       (AMP_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .start_amp        (start_amp),
        .end_amp          (end_amp),
        .start_freq       (start_freq),
        .end_freq         (end_freq),
        .seg_length       (seg_length),
        .hz_to_phase_step (hz_reg),
        .sample           (m_tdata),
        .segment_last     (m_tlast),
        .idle             (m_tuser[0])
    );

endmodule

// File: src/rpo_dp.sv
module rpo_dp #(
    parameter int SEG_LEN_BITS   = rpo_pkg::SEG_LEN_BITS_DEF,
    parameter int SINE_ADDR_BITS = rpo_pkg::SINE_ADDR_BITS_DEF,
    parameter int AMP_BITS       = rpo_pkg::AMP_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rpo_pkg::cmd_t                      cmd,
    output rpo_pkg::stat_t                     stat,
    input  logic [15:0]                        start_amp,
    input  logic [15:0]                        end_amp,
    input  logic [rpo_pkg::FREQ_BITS-1:0]      start_freq,
    input  logic [rpo_pkg::FREQ_BITS-1:0]      end_freq,
    input  logic [15:0]                        seg_length,
    input  logic [rpo_pkg::HZ_BITS-1:0]        hz_to_phase_step,
    output logic [rpo_pkg::SAMPLE_BITS-1:0]    sample,
    output logic                               segment_last,
    output logic                               idle
);

    localparam int FRAC   = rpo_pkg::RAMP_FRAC;
    localparam int FB     = rpo_pkg::FREQ_BITS;
    localparam int AACC_W = AMP_BITS + FRAC;
    localparam int FACC_W = FB + FRAC;
    localparam int DIV_W  = rpo_pkg::div_width(AMP_BITS);
    localparam int SB     = rpo_pkg::SINE_BITS;
    localparam logic [SINE_ADDR_BITS-2:0] QUARTER = {1'b1, {(SINE_ADDR_BITS-2){1'b0}}};

    // input decode
    logic [AMP_BITS-1:0]     a0, a1, amp_mag;
    logic [AMP_BITS:0]       amp_diff, amp_abs;
    logic [FB:0]             freq_diff, freq_abs;
    logic [SEG_LEN_BITS-1:0] len_in;

    // state
    logic [31:0]               phase_reg, phase_next;
    logic [AACC_W-1:0]         amp_acc_reg, amp_acc_next;
    logic signed [AACC_W:0]    amp_step_reg, amp_step_next;
    logic [FACC_W-1:0]         freq_acc_reg, freq_acc_next;
    logic signed [FACC_W:0]    freq_step_reg, freq_step_next;
    logic [SEG_LEN_BITS-1:0]   left_reg, left_next;

    // divider
    logic [SEG_LEN_BITS-1:0]   len_reg, len_next, rem_reg, rem_next;
    logic [DIV_W-1:0]          dq_reg, dq_next;
    logic                      amp_neg_reg, amp_neg_next, freq_neg_reg, freq_neg_next;
    logic [FB-1:0]             freq_mag_reg, freq_mag_next;
    logic [SEG_LEN_BITS:0]     rem_sh, rem_sub;
    logic                      div_ge;
    logic [SEG_LEN_BITS-1:0]   div_rem;
    logic [AACC_W-1:0]         amp_q;
    logic [FACC_W-1:0]         freq_q;
    logic signed [AACC_W:0]    amp_sum;
    logic signed [FACC_W:0]    freq_sum;

    // sine / multiplier
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [1:0]                quad;
    logic [SINE_ADDR_BITS-3:0] r;
    logic [SINE_ADDR_BITS-2:0] pos;
    logic [30:0]               t;
    logic [31:0]               p_mag, mul_a, mul_b;
    logic                      mul_neg;
    logic [63:0]               mul_p;
    logic [63:0]               prod_reg, prod_next;
    logic                      neg_reg, neg_next;
    logic [30:0]               t2_reg, t2_next, y_reg, y_next;
    logic signed [31:0]        p_reg, p_next, q_s, hcoef;
    logic [SB-1:0]             s_reg, s_next, smp_mag, s_sat;
    logic [46:0]               s_wide;
    logic [16:0]               s_full;
    logic [15:0]               smp_reg, smp_next, smp_val;
    logic                      last_reg, last_next;
    logic [15:0]               sample_reg, sample_next;
    logic                      seg_last_reg, seg_last_next, idle_reg, idle_next;

    assign a0     = AMP_BITS'(start_amp);
    assign a1     = AMP_BITS'(end_amp);
    assign len_in = SEG_LEN_BITS'(seg_length);

    assign amp_diff  = {1'b0, a1} - {1'b0, a0};
    assign amp_abs   = amp_diff[AMP_BITS] ? (~amp_diff + 1'b1) : amp_diff;
    assign amp_mag   = amp_abs[AMP_BITS-1:0];
    assign freq_diff = {1'b0, end_freq} - {1'b0, start_freq};
    assign freq_abs  = freq_diff[FB] ? (~freq_diff + 1'b1) : freq_diff;

    assign stat.len_zero     = (len_in == '0);
    assign stat.samples_zero = (left_reg == '0);

    // restoring divider, one quotient bit per step
    assign rem_sh  = {rem_reg, dq_reg[DIV_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, len_reg});
    assign rem_sub = rem_sh - {1'b0, len_reg};
    assign div_rem = div_ge ? rem_sub[SEG_LEN_BITS-1:0] : rem_sh[SEG_LEN_BITS-1:0];
    assign amp_q   = AACC_W'(dq_reg);
    assign freq_q  = FACC_W'(dq_reg);

    assign amp_sum  = $signed({1'b0, amp_acc_reg}) + amp_step_reg;
    assign freq_sum = $signed({1'b0, freq_acc_reg}) + freq_step_reg;

    // quarter-wave fold of the phase
    assign idx  = phase_reg[31 -: SINE_ADDR_BITS];
    assign quad = idx[SINE_ADDR_BITS-1 -: 2];
    assign r    = idx[SINE_ADDR_BITS-3:0];
    assign pos  = quad[0] ? (QUARTER - {1'b0, r}) : {1'b0, r};
    assign t    = {pos, {(32-SINE_ADDR_BITS){1'b0}}};

    assign p_mag = p_reg[31] ? (~p_reg + 32'd1) : p_reg;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (cmd.mul_sel)
            rpo_pkg::MUL_TT: begin
                mul_a = {1'b0, t};
                mul_b = {1'b0, t};
            end
            rpo_pkg::MUL_PT2: begin
                mul_a   = p_mag;
                mul_b   = {1'b0, t2_reg};
                mul_neg = p_reg[31];
            end
            rpo_pkg::MUL_PT: begin
                mul_a   = p_mag;
                mul_b   = {1'b0, t};
                mul_neg = p_reg[31];
            end
            rpo_pkg::MUL_AMP: begin
                mul_a = 32'(amp_acc_reg[AACC_W-1:FRAC]);
                mul_b = 32'(s_reg);
            end
            rpo_pkg::MUL_FRQ: begin
                mul_a = 32'(freq_acc_reg[FACC_W-1:FRAC]);
                mul_b = 32'(hz_to_phase_step);
            end
            default: mul_a = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Q30 product, truncated toward zero
    assign q_s = neg_reg ? -$signed({1'b0, prod_reg[60:30]}) : $signed({1'b0, prod_reg[60:30]});

    always_comb begin
        case (cmd.post_sel)
            rpo_pkg::POST_P7: hcoef = rpo_pkg::COEF_C7;
            rpo_pkg::POST_P5: hcoef = rpo_pkg::COEF_C5;
            rpo_pkg::POST_P3: hcoef = rpo_pkg::COEF_C3;
            rpo_pkg::POST_P1: hcoef = rpo_pkg::COEF_C1;
            default:          hcoef = '0;
        endcase
    end

    // y * 32767 rounded back to Q15
    assign s_wide  = {1'b0, y_reg, 15'b0} - {16'b0, y_reg} + (47'd1 << 29);
    assign s_full  = s_wide[46:30];
    assign s_sat   = (s_full > 17'd32767) ? {SB{1'b1}} : s_full[SB-1:0];
    assign smp_mag = prod_reg[AMP_BITS +: SB];
    assign smp_val = quad[1] ? (16'd0 - {1'b0, smp_mag}) : {1'b0, smp_mag};

    always_comb begin
        phase_next     = phase_reg;
        amp_acc_next   = amp_acc_reg;
        amp_step_next  = amp_step_reg;
        freq_acc_next  = freq_acc_reg;
        freq_step_next = freq_step_reg;
        left_next      = left_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        amp_neg_next   = amp_neg_reg;
        freq_neg_next  = freq_neg_reg;
        freq_mag_next  = freq_mag_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        t2_next        = t2_reg;
        p_next         = p_reg;
        y_next         = y_reg;
        s_next         = s_reg;
        smp_next       = smp_reg;
        last_next      = last_reg;
        sample_next    = sample_reg;
        seg_last_next  = seg_last_reg;
        idle_next      = idle_reg;

        if (cmd.phase_clr) begin
            phase_next = '0;
        end
        if (cmd.seg_load) begin
            amp_acc_next  = {a0, {FRAC{1'b0}}};
            freq_acc_next = {start_freq, {FRAC{1'b0}}};
            left_next     = len_in;
            len_next      = len_in;
            amp_neg_next  = amp_diff[AMP_BITS];
            freq_neg_next = freq_diff[FB];
            freq_mag_next = freq_abs[FB-1:0];
            dq_next       = DIV_W'({amp_mag, {FRAC{1'b0}}});
            rem_next      = '0;
        end
        if (cmd.div_step) begin
            dq_next  = {dq_reg[DIV_W-2:0], div_ge};
            rem_next = div_rem;
        end
        if (cmd.div_amp_done) begin
            amp_step_next = amp_neg_reg ? -$signed({1'b0, amp_q}) : $signed({1'b0, amp_q});
            dq_next       = DIV_W'({freq_mag_reg, {FRAC{1'b0}}});
            rem_next      = '0;
        end
        if (cmd.div_freq_done) begin
            freq_step_next = freq_neg_reg ? -$signed({1'b0, freq_q}) : $signed({1'b0, freq_q});
        end
        if (cmd.mul_sel != rpo_pkg::MUL_NONE) begin
            prod_next = mul_p;
            neg_next  = mul_neg;
        end
        case (cmd.post_sel)
            rpo_pkg::POST_T2: begin
                t2_next = prod_reg[60:30];
                p_next  = rpo_pkg::COEF_C9;
            end
            rpo_pkg::POST_P7, rpo_pkg::POST_P5, rpo_pkg::POST_P3, rpo_pkg::POST_P1: begin
                p_next = hcoef + q_s;
            end
            rpo_pkg::POST_Y: begin
                y_next = q_s[31] ? '0 : q_s[30:0];
            end
            rpo_pkg::POST_S: begin
                s_next = s_sat;
            end
            rpo_pkg::POST_SMP: begin
                smp_next  = smp_val;
                last_next = (left_reg == SEG_LEN_BITS'(1));
            end
            rpo_pkg::POST_UPD: begin
                phase_next    = phase_reg + prod_reg[47:16];
                amp_acc_next  = amp_sum[AACC_W-1:0];
                freq_acc_next = freq_sum[FACC_W-1:0];
                left_next     = left_reg - SEG_LEN_BITS'(1);
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            sample_next   = cmd.out_idle ? '0 : smp_reg;
            seg_last_next = cmd.out_idle ? 1'b0 : last_reg;
            idle_next     = cmd.out_idle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            amp_acc_reg   <= '0;
            amp_step_reg  <= '0;
            freq_acc_reg  <= '0;
            freq_step_reg <= '0;
            left_reg      <= '0;
        end else begin
            phase_reg     <= phase_next;
            amp_acc_reg   <= amp_acc_next;
            amp_step_reg  <= amp_step_next;
            freq_acc_reg  <= freq_acc_next;
            freq_step_reg <= freq_step_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        amp_neg_reg  <= amp_neg_next;
        freq_neg_reg <= freq_neg_next;
        freq_mag_reg <= freq_mag_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        t2_reg       <= t2_next;
        p_reg        <= p_next;
        y_reg        <= y_next;
        s_reg        <= s_next;
        smp_reg      <= smp_next;
        last_reg     <= last_next;
        sample_reg   <= sample_next;
        seg_last_reg <= seg_last_next;
        idle_reg     <= idle_next;
    end

    assign sample       = sample_reg;
    assign segment_last = seg_last_reg;
    assign idle         = idle_reg;

endmodule

// File: src/rpo_ctrl.sv
module rpo_ctrl #(
    parameter int AMP_BITS = rpo_pkg::AMP_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rpo_pkg::opcode_t opcode,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  rpo_pkg::stat_t   stat,
    output rpo_pkg::cmd_t    cmd
);

    localparam int DIV_W = rpo_pkg::div_width(AMP_BITS);
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int SW    = rpo_pkg::TICK_STEP_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV_AMP = 3'd1;
    localparam logic [2:0] ST_DIV_FRQ = 3'd2;
    localparam logic [2:0] ST_TICK    = 3'd3;
    localparam logic [2:0] ST_OUT     = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]    step_reg, step_next;
    logic             idle_pend_reg, idle_pend_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept, out_free;
    rpo_pkg::uop_t    uop;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign uop      = rpo_pkg::tick_uop(step_reg);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        idle_pend_next = idle_pend_reg;
        cmd            = '0;
        cmd.mul_sel    = rpo_pkg::MUL_NONE;
        cmd.post_sel   = rpo_pkg::POST_NONE;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (opcode)
                        rpo_pkg::OP_NEW: begin
                            cmd.phase_clr = 1'b1;
                        end
                        rpo_pkg::OP_LOAD: begin
                            if (!stat.len_zero) begin
                                cmd.seg_load = 1'b1;
                                cnt_next     = '0;
                                state_next   = ST_DIV_AMP;
                            end
                        end
                        rpo_pkg::OP_TICK: begin
                            if (stat.samples_zero) begin
                                idle_pend_next = 1'b1;
                                state_next     = ST_OUT;
                            end else begin
                                idle_pend_next = 1'b0;
                                step_next      = '0;
                                state_next     = ST_TICK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV_AMP: begin
                if (cnt_reg == CNT_W'(DIV_W)) begin
                    cmd.div_amp_done = 1'b1;
                    cnt_next         = '0;
                    state_next       = ST_DIV_FRQ;
                end else begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
            end
            ST_DIV_FRQ: begin
                if (cnt_reg == CNT_W'(DIV_W)) begin
                    cmd.div_freq_done = 1'b1;
                    state_next        = ST_IDLE;
                end else begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
            end
            ST_TICK: begin
                cmd.mul_sel  = uop.mul_sel;
                cmd.post_sel = uop.post_sel;
                if (step_reg == SW'(rpo_pkg::TICK_STEPS - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    step_next = step_reg + SW'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_idle = idle_pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            idle_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            idle_pend_reg <= idle_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // no datapath work while a new word is taken
    a_accept_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (cmd.mul_sel == rpo_pkg::MUL_NONE && !cmd.div_step && !cmd.out_load))
        else $error("datapath busy while taking a word");

    // the result register only fills from the sequencer
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.out_load))
        else $error("m_tvalid rose without a load");

    // a computed sample always has samples left at its start
    a_tick_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK && step_reg == '0) |-> !stat.samples_zero)
        else $error("sample computed with no samples left");

    // a stalled result keeps the next one parked
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result overwritten under back-pressure");

    // both steps done puts the block back to taking words
    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_freq_done |=> s_tready)
        else $error("no return to idle after the divide");

endmodule

// File: tb/ramped_partial_oscillator_top_tb.sv
`timescale 1ns / 1ps

module ramped_partial_oscillator_top_tb;

    // spare opcode, must be swallowed without a result
    localparam rpo_pkg::opcode_t OP_SPARE    = 2'd3;
    localparam logic [2:0]       REG_HZ_STEP = 3'(4 * rpo_pkg::REG_HZ_IDX);

    localparam logic [27:0] HZ_AT_RESET = 28'd22906493;
    localparam int          STEP_FRAC   = 16;   // ramp accumulators carry 16 extra bits
    localparam int          AMP_W       = 16;
    localparam int          ADDR_W      = 10;   // sine index bits taken from the phase
    localparam int          ITEM_TARGET = 1200;
    localparam int          N_PHASES    = 7;
    // settle margin, longer than a segment load keeps the divider busy
    localparam int          SETTLE_CYCLES = 120;
    localparam longint      CYCLE_LIMIT   = 2_000_000;

    // Q30 odd-power sine polynomial
    localparam longint C1 = 1686629713;
    localparam longint C3 = -693598668;
    localparam longint C5 = 85569306;
    localparam longint C7 = -5026995;
    localparam longint C9 = 172272;

    typedef struct packed {
        logic [15:0] smp;
        logic        last;
        logic        idle;
    } osc_result_t;

    // Tracks the oscillator state and holds the samples still owed by the block.
    class osc_scoreboard;
        logic [27:0]   rate;
        logic [31:0]   phase;
        longint        amp_acc, amp_step, freq_acc, freq_step;
        int unsigned   left;
        osc_result_t   wanted_q[$];
        int            fails, n_tick, n_load, n_new, n_ignored, n_checked, n_idle, n_last;

        function new();
            rate      = HZ_AT_RESET;
            phase     = '0;
            amp_acc   = 0;
            amp_step  = 0;
            freq_acc  = 0;
            freq_step = 0;
            left      = 0;
        endfunction

        function void fail(string msg);
            fails++;
            if (fails <= 10) $display("%s", msg);
        endfunction

        function void set_rate(logic [31:0] v);
            rate = v[27:0];
        endfunction

        function int pending();
            return wanted_q.size();
        endfunction

        // sign-magnitude product, truncated toward zero
        function longint q30_mul(longint a, longint b);
            longint ma, mb, m;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            m  = (ma * mb) >>> 30;
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function longint quarter_sine(longint t);
            longint t2, p, y, s;
            t2 = q30_mul(t, t);
            p  = C9;
            p  = C7 + q30_mul(p, t2);
            p  = C5 + q30_mul(p, t2);
            p  = C3 + q30_mul(p, t2);
            p  = C1 + q30_mul(p, t2);
            y  = q30_mul(p, t);
            if (y < 0) y = 0;
            s = (y * 32767 + (longint'(1) <<< 29)) >>> 30;
            if (s > 32767) s = 32767;
            return s;
        endfunction

        function longint sine_of_phase(logic [31:0] ph);
            logic [ADDR_W-1:0] idx;
            logic [1:0]        quad;
            longint            r, pos, s;
            idx  = ph[31 -: ADDR_W];
            quad = idx[ADDR_W-1 -: 2];
            r    = idx[ADDR_W-3:0];
            // odd quadrants run the quarter wave backwards
            pos  = quad[0] ? (longint'(1) << (ADDR_W - 2)) - r : r;
            s    = quarter_sine(pos << (32 - ADDR_W));
            return quad[1] ? -s : s;
        endfunction

        function longint ramp(longint from, longint to, longint len);
            longint diff, q;
            diff = to - from;
            q    = (((diff < 0) ? -diff : diff) << STEP_FRAC) / len;
            return (diff < 0) ? -q : q;
        endfunction

        function void note_word(rpo_pkg::opcode_t op, logic [95:0] d);
            longint      sa, ea, sf, ef, len, amp_int, s, mag, inc;
            osc_result_t r;
            sa  = d[15:0];
            ea  = d[31:16];
            sf  = d[54:32];
            ef  = d[77:55];
            len = d[93:78];
            case (op)
                rpo_pkg::OP_NEW: begin
                    phase = '0;
                    n_new++;
                end
                rpo_pkg::OP_LOAD: begin
                    if (len == 0) begin
                        n_ignored++;
                    end else begin
                        amp_acc   = sa << STEP_FRAC;
                        freq_acc  = sf << STEP_FRAC;
                        amp_step  = ramp(sa, ea, len);
                        freq_step = ramp(sf, ef, len);
                        left      = len;
                        n_load++;
                    end
                end
                rpo_pkg::OP_TICK: begin
                    n_tick++;
                    if (left == 0) begin
                        // nothing left: silent, marked idle, phase frozen
                        r.smp  = '0;
                        r.last = 1'b0;
                        r.idle = 1'b1;
                    end else begin
                        amp_int = amp_acc >>> STEP_FRAC;
                        s       = sine_of_phase(phase);
                        mag     = (amp_int * ((s < 0) ? -s : s)) >>> AMP_W;
                        r.smp   = 16'((s < 0) ? -mag : mag);
                        r.last  = (left == 1);
                        r.idle  = 1'b0;
                        inc     = ((freq_acc >>> STEP_FRAC) * longint'(rate)) >>> 16;
                        phase   = phase + inc[31:0];
                        amp_acc  += amp_step;
                        freq_acc += freq_step;
                        left--;
                    end
                    wanted_q.push_back(r);
                end
                default: n_ignored++;
            endcase
        endfunction

        function void check_result(logic [15:0] smp, logic last, logic idle);
            osc_result_t w;
            if (wanted_q.size() == 0) begin
                fail($sformatf("unexpected word: sample %0d last %b idle %b",
                               $signed(smp), last, idle));
                return;
            end
            w = wanted_q.pop_front();
            n_checked++;
            if (w.idle) n_idle++;
            if (w.last) n_last++;
            if (smp !== w.smp || last !== w.last || idle !== w.idle)
                fail($sformatf("word %0d: sample %0d/%0d last %b/%b idle %b/%b (exp/got)",
                               n_checked, $signed(w.smp), $signed(smp),
                               w.last, last, w.idle, idle));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // start_amp, end_amp, start_freq, end_freq, seg_length
    logic [1:0]  s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // sample
    logic        m_tlast;   // segment_last
    logic [0:0]  m_tuser;   // idle
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    osc_scoreboard board;
    longint        cycles = 0;
    int            items = 0;      // words that the block acts on
    int            burst_left = 0;
    bit            steady = 1'b0;  // back-to-back words, no sender gaps

    ramped_partial_oscillator_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, board.pending());
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check each accepted word, then pick the next ready level.
    // The stall pattern rotates through four modes: always ready, mostly ready,
    // mostly stalled, and a fixed repeating stall comb.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tlast, m_tuser[0]);
        case ((cycles / 700) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycles % 23) >= 15);
        endcase
    end

    function automatic logic [95:0] pack_seg(logic [15:0] sa, logic [15:0] ea,
                                             logic [22:0] sf, logic [22:0] ef,
                                             logic [15:0] len);
        return {2'b00, len, ef, sf, ea, sa};
    endfunction

    function automatic logic [95:0] rnd_word();
        return {2'b00, 30'($urandom), $urandom, $urandom};
    endfunction

    // extremes turn up often enough to matter
    function automatic logic [15:0] rnd_amp();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [22:0] rnd_freq();
        case ($urandom_range(0, 9))
            0:       return 23'd0;
            1:       return 23'h7FFFFF;
            default: return 23'($urandom_range(0, 23'h7FFFFF));
        endcase
    endfunction

    // One word on the input side. Bursts of random length, random gaps between them.
    task automatic send_word(rpo_pkg::opcode_t op, logic [95:0] d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(30, 70);
                default: gap = $urandom_range(1, 25);
            endcase
            if (steady) gap = 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_word(op, d);
        if (op != OP_SPARE && !(op == rpo_pkg::OP_LOAD && d[93:78] == 16'd0)) items++;
    endtask

    // hold the input side until every owed word is back and the divider is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one transfer, then the bus goes idle before the next one may start
    task automatic apb_access(logic wr, logic [2:0] a, logic [31:0] wd,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= wd;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        if (wr && a == REG_HZ_STEP) board.set_rate(wd);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic verify_rate();
        logic [31:0] rd;
        apb_access(1'b0, REG_HZ_STEP, 32'd0, rd);
        if (rd !== {4'd0, board.rate})
            board.fail($sformatf("rate register reads %0d, expected %0d", rd, board.rate));
    endtask

    initial begin
        logic [31:0] plan [N_PHASES];
        logic [31:0] rd_back;
        int          len, n;

        board = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= rpo_pkg::OP_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        // rate per phase; the first phase runs on the reset value.
        // All-ones checks that the upper four bits are dropped.
        plan[0] = {4'd0, HZ_AT_RESET};
        plan[1] = 32'd5726623;
        plan[2] = 32'd137438954;
        plan[3] = 32'hFFFF_FFFF;
        plan[4] = 32'd0;
        plan[5] = $urandom_range(5726623, 137438954);
        plan[6] = {4'd0, HZ_AT_RESET};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        verify_rate();

        // directed opening
        send_word(rpo_pkg::OP_TICK, '0);        // idle straight out of reset
        send_word(OP_SPARE, rnd_word());        // spare opcode, no result
        send_word(rpo_pkg::OP_LOAD,
                  pack_seg(16'hFFFF, 16'hFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'd0));
        send_word(rpo_pkg::OP_TICK, '0);        // zero length left us idle
        // full-scale fade-out with falling frequency, then past its end
        send_word(rpo_pkg::OP_LOAD, pack_seg(16'hFFFF, 16'd0, 23'h7FFFFF, 23'd0, 16'd3));
        repeat (4) send_word(rpo_pkg::OP_TICK, '0);
        send_word(rpo_pkg::OP_NEW, '0);
        // longest segment, rising ramps; cut short below
        send_word(rpo_pkg::OP_LOAD, pack_seg(16'd0, 16'hFFFF, 23'd0, 23'h7FFFFF, 16'hFFFF));
        repeat (3) send_word(rpo_pkg::OP_TICK, rnd_word());
        send_word(rpo_pkg::OP_NEW, '0);         // phase only, ramps carry on
        send_word(rpo_pkg::OP_TICK, '0);
        // load on top of a running segment
        send_word(rpo_pkg::OP_LOAD,
                  pack_seg(16'hFFFF, 16'hFFFF, 23'd12800, 23'd256000, 16'd2));
        repeat (3) send_word(rpo_pkg::OP_TICK, '0);
        send_word(rpo_pkg::OP_LOAD, pack_seg(16'hFFFF, 16'd1, 23'd0, 23'd0, 16'd1));
        send_word(rpo_pkg::OP_TICK, '0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                apb_access(1'b1, REG_HZ_STEP, plan[ph], rd_back);
                verify_rate();
            end
            while (items < ((ph + 1) * ITEM_TARGET) / N_PHASES) begin
                steady = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 19))
                    0: send_word(OP_SPARE, rnd_word());
                    1: send_word(rpo_pkg::OP_LOAD, pack_seg(rnd_amp(), rnd_amp(), rnd_freq(),
                                                            rnd_freq(), 16'd0));
                    default: begin
                        // a segment: optional new partial, load, then ticks
                        if ($urandom_range(0, 3) == 0) send_word(rpo_pkg::OP_NEW, rnd_word());
                        case ($urandom_range(0, 19))
                            16, 17, 18: len = $urandom_range(25, 200);
                            19:         len = $urandom_range(1, 65535);
                            default:    len = $urandom_range(1, 24);
                        endcase
                        send_word(rpo_pkg::OP_LOAD, pack_seg(rnd_amp(), rnd_amp(), rnd_freq(),
                                                             rnd_freq(), 16'(len)));
                        // long ones and some short ones get replaced before they end
                        if (len > 200)
                            n = $urandom_range(1, 30);
                        else if ($urandom_range(0, 4) == 0)
                            n = $urandom_range(1, len);
                        else
                            n = len + $urandom_range(0, 3);
                        for (int i = 0; i < n; i++) begin
                            if ($urandom_range(0, 49) == 0)
                                send_word(rpo_pkg::OP_NEW, rnd_word());
                            else
                                send_word(rpo_pkg::OP_TICK, rnd_word());
                        end
                    end
                endcase
            end
        end

        settle();
        $display("ran %0d ticks, %0d segment loads, %0d new partials, %0d ignored words, %0d rates",
                 board.n_tick, board.n_load, board.n_new, board.n_ignored, N_PHASES);
        $display("checked %0d samples (%0d idle, %0d segment ends), %0d failures",
                 board.n_checked, board.n_idle, board.n_last, board.fails);
        if (board.fails == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
src/rpo_pkg.sv
src/rpo_dp.sv
src/rpo_ctrl.sv
src/ramped_partial_oscillator_top.sv
tb/ramped_partial_oscillator_top_tb.sv
